@@ design/nldm_table_bilinear_interpolator_assert.svh @@
// Assertion macros for the checker file of the table interpolator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef NLDM_TABLE_BILINEAR_INTERPOLATOR_ASSERT_SVH
`define NLDM_TABLE_BILINEAR_INTERPOLATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NTBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NTBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ntbi_pkg.sv @@
package ntbi_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DIM  = 7;
  localparam int NUM_TABLES = 32;
  localparam int VAL_W      = 32;
  localparam int TAB_W      = 5;
  localparam int POS_W      = 3;
  localparam int SEG_W      = 3;
  localparam int AX_DEPTH   = NUM_TABLES * TABLE_DIM;
  localparam int AX_AW      = $clog2(AX_DEPTH);
  localparam int GRID_DEPTH = AX_DEPTH * TABLE_DIM;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);

  // Arithmetic widths: magnitudes, products and the wide accumulator.
  localparam int MAG_W  = 32;
  localparam int PROD_W = 2 * MAG_W;
  localparam int ACC_W  = 100;

  // Sequencer step counts.
  localparam int CNT_W      = 6;
  localparam int FETCH_LAST = 6;
  localparam int MUL_TERMS  = 16;
  localparam int MUL_LAST   = 17;
  localparam int DIV_LAST   = MAG_W;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    FUNC_SLEW  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_GRID  = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX,
    ST_FETCH,
    ST_PREP,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_MUL_D,
    MOP_MUL_LO,
    MOP_MUL_HI,
    MOP_ACC_HI,
    MOP_MUL_DEN
  } mop_t;

  typedef struct packed {
    logic             wr_en;
    logic             load_q;
    logic             scan_rd;
    logic             scan_proc;
    logic             seg_fix;
    logic             fetch_cap;
    logic             prep;
    mop_t             mop;
    logic [1:0]       term;
    logic             div_init;
    logic             div_step;
    logic             out_load;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic tab_bad;
    logic degen;
  } dp_stat_t;

endpackage

@@ design/ntbi_ctrl.sv @@
module ntbi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_func,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ntbi_pkg::dp_stat_t  stat,
  output ntbi_pkg::dp_cmd_t   cmd
);

  ntbi_pkg::state_t               state_r, state_nxt;
  logic [ntbi_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           is_query;
  logic                           slot_free;

  assign is_query  = (in_func == ntbi_pkg::FUNC_QUERY);
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ntbi_pkg::ST_IDLE: begin
        if (in_valid && is_query) begin
          state_nxt = stat.tab_bad ? ntbi_pkg::ST_DONE : ntbi_pkg::ST_SCAN;
        end
      end
      ntbi_pkg::ST_SCAN: begin
        if (cnt_r == ntbi_pkg::CNT_W'(ntbi_pkg::TABLE_DIM)) state_nxt = ntbi_pkg::ST_FIX;
      end
      ntbi_pkg::ST_FIX: state_nxt = ntbi_pkg::ST_FETCH;
      ntbi_pkg::ST_FETCH: begin
        if (cnt_r == ntbi_pkg::CNT_W'(ntbi_pkg::FETCH_LAST)) state_nxt = ntbi_pkg::ST_PREP;
      end
      ntbi_pkg::ST_PREP: begin
        state_nxt = stat.degen ? ntbi_pkg::ST_DONE : ntbi_pkg::ST_MUL;
      end
      ntbi_pkg::ST_MUL: begin
        if (cnt_r == ntbi_pkg::CNT_W'(ntbi_pkg::MUL_LAST)) state_nxt = ntbi_pkg::ST_DIV_INIT;
      end
      ntbi_pkg::ST_DIV_INIT: state_nxt = ntbi_pkg::ST_DIV;
      ntbi_pkg::ST_DIV: begin
        if (cnt_r == ntbi_pkg::CNT_W'(ntbi_pkg::DIV_LAST)) state_nxt = ntbi_pkg::ST_DONE;
      end
      ntbi_pkg::ST_DONE: begin
        if (slot_free) state_nxt = ntbi_pkg::ST_IDLE;
      end
      default: state_nxt = ntbi_pkg::ST_IDLE;
    endcase
  end

  // Step counter restarts on every state change.
  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + ntbi_pkg::CNT_W'(1);

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.mop       = ntbi_pkg::MOP_NONE;
    cmd.idx       = cnt_r;
    cmd.term      = cnt_r[3:2];
    in_ready      = 1'b0;
    unique case (state_r)
      ntbi_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.wr_en  = in_valid && !is_query;
        cmd.load_q = in_valid && is_query;
      end
      ntbi_pkg::ST_SCAN: begin
        cmd.scan_rd   = (cnt_r < ntbi_pkg::CNT_W'(ntbi_pkg::TABLE_DIM));
        cmd.scan_proc = (cnt_r != '0);
      end
      ntbi_pkg::ST_FIX:   cmd.seg_fix = 1'b1;
      ntbi_pkg::ST_FETCH: cmd.fetch_cap = (cnt_r != '0);
      ntbi_pkg::ST_PREP:  cmd.prep = 1'b1;
      ntbi_pkg::ST_MUL: begin
        if (cnt_r < ntbi_pkg::CNT_W'(ntbi_pkg::MUL_TERMS)) begin
          case (cnt_r[1:0])
            2'd0:    cmd.mop = ntbi_pkg::MOP_MUL_D;
            2'd1:    cmd.mop = ntbi_pkg::MOP_MUL_LO;
            2'd2:    cmd.mop = ntbi_pkg::MOP_MUL_HI;
            default: cmd.mop = ntbi_pkg::MOP_ACC_HI;
          endcase
        end else if (cnt_r == ntbi_pkg::CNT_W'(ntbi_pkg::MUL_TERMS)) begin
          cmd.mop = ntbi_pkg::MOP_MUL_DEN;
        end
      end
      ntbi_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      ntbi_pkg::ST_DIV:      cmd.div_step = 1'b1;
      ntbi_pkg::ST_DONE:     cmd.out_load = slot_free;
      default: ;
    endcase
  end

  // Result word handshake.
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntbi_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/ntbi_dp.sv @@
module ntbi_dp (
  input  logic                          clk,
  input  logic [1:0]                    in_func,
  input  logic [ntbi_pkg::TAB_W-1:0]    in_table_id,
  input  logic [ntbi_pkg::POS_W-1:0]    in_row_pos,
  input  logic [ntbi_pkg::POS_W-1:0]    in_col_pos,
  input  logic signed [ntbi_pkg::VAL_W-1:0] in_write_value,
  input  logic signed [ntbi_pkg::VAL_W-1:0] in_query_slew,
  input  logic signed [ntbi_pkg::VAL_W-1:0] in_query_load,
  input  ntbi_pkg::dp_cmd_t             cmd,
  output ntbi_pkg::dp_stat_t            stat,
  output logic signed [ntbi_pkg::VAL_W-1:0] out_value,
  output logic [ntbi_pkg::SEG_W-1:0]    out_row_segment,
  output logic [ntbi_pkg::SEG_W-1:0]    out_col_segment,
  output logic                          out_degenerate
);

  localparam int VW = ntbi_pkg::VAL_W;
  localparam int MW = ntbi_pkg::MAG_W;
  localparam int AW = ntbi_pkg::ACC_W;

  // Signed difference a - b as {negative, magnitude}.
  function automatic logic [MW:0] sdiff(input logic signed [VW-1:0] a,
                                        input logic signed [VW-1:0] b);
    logic [VW:0] d;
    logic [VW:0] n;
    d = {a[VW-1], a} - {b[VW-1], b};
    n = (VW+1)'(0) - d;
    return {d[VW], d[VW] ? n[MW-1:0] : d[MW-1:0]};
  endfunction

  // Table memories.
  logic [VW-1:0] slew_mem [ntbi_pkg::AX_DEPTH];
  logic [VW-1:0] load_mem [ntbi_pkg::AX_DEPTH];
  logic [VW-1:0] grid_mem [ntbi_pkg::GRID_DEPTH];

  logic                            tab_ok, row_ok, col_ok;
  logic                            slew_we, load_we, grid_we;
  logic [ntbi_pkg::AX_AW-1:0]      wax_row, wax_col;
  logic [ntbi_pkg::GRID_AW-1:0]    wgrid;
  logic [ntbi_pkg::POS_W-1:0]      ax_off [2];
  logic [ntbi_pkg::AX_AW-1:0]      rax [2];
  logic [1:0]                      gk;
  logic [ntbi_pkg::POS_W-1:0]      gr, gc;
  logic [ntbi_pkg::GRID_AW-1:0]    rgrid;
  logic [ntbi_pkg::CNT_W-1:0]      j;

  logic signed [VW-1:0]            ax_rd_r [2];
  logic signed [VW-1:0]            grid_rd_r;
  logic [ntbi_pkg::TAB_W-1:0]      tab_r;
  logic                            tab_bad_r;
  logic signed [VW-1:0]            x_r [2];
  logic signed [VW-1:0]            prev_r [2];
  logic signed [VW-1:0]            a0_r [2];
  logic                            found_r [2];
  logic [ntbi_pkg::SEG_W-1:0]      seg_r [2];
  logic signed [VW-1:0]            lo_r [2];
  logic signed [VW-1:0]            hi_r [2];
  logic signed [VW-1:0]            v_r [4];

  logic [MW:0]                     df [6];
  logic [MW-1:0]                   dm_r [6];
  logic                            dn_r [6];
  logic [MW-1:0]                   vm [4];
  logic [MW-1:0]                   vmag_r [4];
  logic                            vneg_r [4];

  logic [MW-1:0]                   mul_a, mul_b;
  logic [ntbi_pkg::PROD_W-1:0]     mul_p;
  logic [ntbi_pkg::PROD_W-1:0]     mul_r;
  logic [MW-1:0]                   phi_r;
  logic                            tneg_r, dneg_r;
  logic [AW-1:0]                   acc_r, addend, acc_sum;
  logic [2:0]                      dc_i, dt_i;

  logic [AW-1:0]                   rem_r, dsh_r;
  logic [MW:0]                     q_r;
  logic                            qneg_r;
  logic                            ge;

  logic                            degen;
  logic [VW-1:0]                   val;

  // Write decode.
  assign tab_ok  = {1'b0, in_table_id} < (ntbi_pkg::TAB_W+1)'(ntbi_pkg::NUM_TABLES);
  assign row_ok  = {1'b0, in_row_pos} < (ntbi_pkg::POS_W+1)'(ntbi_pkg::TABLE_DIM);
  assign col_ok  = {1'b0, in_col_pos} < (ntbi_pkg::POS_W+1)'(ntbi_pkg::TABLE_DIM);
  assign slew_we = cmd.wr_en && tab_ok && row_ok && (in_func == ntbi_pkg::FUNC_SLEW);
  assign load_we = cmd.wr_en && tab_ok && col_ok && (in_func == ntbi_pkg::FUNC_LOAD);
  assign grid_we = cmd.wr_en && tab_ok && row_ok && col_ok
                   && (in_func == ntbi_pkg::FUNC_GRID);
  assign wax_row = ntbi_pkg::AX_AW'(int'(in_table_id) * ntbi_pkg::TABLE_DIM
                                    + int'(in_row_pos));
  assign wax_col = ntbi_pkg::AX_AW'(int'(in_table_id) * ntbi_pkg::TABLE_DIM
                                    + int'(in_col_pos));
  assign wgrid   = ntbi_pkg::GRID_AW'((int'(in_table_id) * ntbi_pkg::TABLE_DIM
                                      + int'(in_row_pos)) * ntbi_pkg::TABLE_DIM
                                      + int'(in_col_pos));

  assign stat.tab_bad = !tab_ok;

  // Read addresses: axis scan by step, then the two segment end points, then
  // the four grid corners.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ax_off[a] = cmd.scan_rd ? cmd.idx[ntbi_pkg::POS_W-1:0]
                              : ntbi_pkg::POS_W'(seg_r[a])
                                + ntbi_pkg::POS_W'(cmd.idx == ntbi_pkg::CNT_W'(1));
      rax[a]    = ntbi_pkg::AX_AW'(int'(tab_r) * ntbi_pkg::TABLE_DIM + int'(ax_off[a]));
    end
  end

  assign gk    = 2'(cmd.idx - ntbi_pkg::CNT_W'(2));
  assign gr    = ntbi_pkg::POS_W'(seg_r[0]) + ntbi_pkg::POS_W'(gk[1]);
  assign gc    = ntbi_pkg::POS_W'(seg_r[1]) + ntbi_pkg::POS_W'(gk[0]);
  assign rgrid = ntbi_pkg::GRID_AW'((int'(tab_r) * ntbi_pkg::TABLE_DIM + int'(gr))
                                    * ntbi_pkg::TABLE_DIM + int'(gc));

  // Memory ports, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (slew_we) slew_mem[wax_row] <= in_write_value;
    ax_rd_r[0] <= slew_mem[rax[0]];
  end

  always_ff @(posedge clk) begin
    if (load_we) load_mem[wax_col] <= in_write_value;
    ax_rd_r[1] <= load_mem[rax[1]];
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[wgrid] <= in_write_value;
    grid_rd_r <= grid_mem[rgrid];
  end

  // Data read back belongs to the previous step.
  assign j = cmd.idx - ntbi_pkg::CNT_W'(1);

  // Query capture, segment search, end point and corner capture.
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      tab_r     <= in_table_id;
      tab_bad_r <= !tab_ok;
      x_r[0]    <= in_query_slew;
      x_r[1]    <= in_query_load;
      found_r[0] <= 1'b0;
      found_r[1] <= 1'b0;
    end
    for (int a = 0; a < 2; a++) begin
      if (cmd.scan_proc) begin
        if (j == '0) begin
          a0_r[a] <= ax_rd_r[a];
        end else if (!found_r[a] && x_r[a] >= prev_r[a] && x_r[a] <= ax_rd_r[a]) begin
          seg_r[a]   <= ntbi_pkg::SEG_W'(j - ntbi_pkg::CNT_W'(1));
          found_r[a] <= 1'b1;
        end
        prev_r[a] <= ax_rd_r[a];
      end
      if (cmd.seg_fix && !found_r[a]) begin
        seg_r[a] <= (x_r[a] < a0_r[a]) ? '0 : ntbi_pkg::SEG_W'(ntbi_pkg::TABLE_DIM - 2);
      end
    end
    if (cmd.fetch_cap) begin
      case (j)
        ntbi_pkg::CNT_W'(0): begin
          lo_r[0] <= ax_rd_r[0];
          lo_r[1] <= ax_rd_r[1];
        end
        ntbi_pkg::CNT_W'(1): begin
          hi_r[0] <= ax_rd_r[0];
          hi_r[1] <= ax_rd_r[1];
        end
        default: v_r[2'(j - ntbi_pkg::CNT_W'(2))] <= grid_rd_r;
      endcase
    end
  end

  assign degen      = (lo_r[0] == hi_r[0]) || (lo_r[1] == hi_r[1]);
  assign stat.degen = degen;

  // Differences (slew side, load side, the two segment widths) and corner magnitudes.
  always_comb begin
    df[0] = sdiff(x_r[0], lo_r[0]);
    df[1] = sdiff(hi_r[0], x_r[0]);
    df[2] = sdiff(x_r[1], lo_r[1]);
    df[3] = sdiff(hi_r[1], x_r[1]);
    df[4] = sdiff(hi_r[0], lo_r[0]);
    df[5] = sdiff(hi_r[1], lo_r[1]);
    for (int k = 0; k < 4; k++) begin
      vm[k] = v_r[k][VW-1] ? MW'(0) - MW'(v_r[k]) : MW'(v_r[k]);
    end
  end

  // Term k weights corner k by one load and one slew distance.
  assign dc_i = cmd.term[0] ? 3'd2 : 3'd3;
  assign dt_i = cmd.term[1] ? 3'd0 : 3'd1;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mop)
      ntbi_pkg::MOP_MUL_D: begin
        mul_a = dm_r[dc_i];
        mul_b = dm_r[dt_i];
      end
      ntbi_pkg::MOP_MUL_LO: begin
        mul_a = mul_r[MW-1:0];
        mul_b = vmag_r[cmd.term];
      end
      ntbi_pkg::MOP_MUL_HI: begin
        mul_a = phi_r;
        mul_b = vmag_r[cmd.term];
      end
      ntbi_pkg::MOP_MUL_DEN: begin
        mul_a = dm_r[5];
        mul_b = dm_r[4];
      end
      default: ;
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign addend  = (cmd.mop == ntbi_pkg::MOP_ACC_HI) ? (AW'(mul_r) << MW) : AW'(mul_r);
  assign acc_sum = tneg_r ? acc_r - addend : acc_r + addend;
  assign ge      = rem_r >= dsh_r;

  // Product accumulation and restoring division.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      for (int i = 0; i < 6; i++) begin
        dm_r[i] <= df[i][MW-1:0];
        dn_r[i] <= df[i][MW];
      end
      for (int k = 0; k < 4; k++) begin
        vmag_r[k] <= vm[k];
        vneg_r[k] <= v_r[k][VW-1];
      end
      acc_r <= '0;
    end
    case (cmd.mop)
      ntbi_pkg::MOP_MUL_D: begin
        mul_r  <= mul_p;
        tneg_r <= dn_r[dc_i] ^ dn_r[dt_i] ^ vneg_r[cmd.term];
      end
      ntbi_pkg::MOP_MUL_LO: begin
        mul_r <= mul_p;
        phi_r <= mul_r[ntbi_pkg::PROD_W-1:MW];
      end
      ntbi_pkg::MOP_MUL_HI: begin
        acc_r <= acc_sum;
        mul_r <= mul_p;
      end
      ntbi_pkg::MOP_ACC_HI: acc_r <= acc_sum;
      ntbi_pkg::MOP_MUL_DEN: begin
        mul_r  <= mul_p;
        dneg_r <= dn_r[5] ^ dn_r[4];
      end
      default: ;
    endcase
    if (cmd.div_init) begin
      rem_r  <= acc_r[AW-1] ? AW'(0) - acc_r : acc_r;
      qneg_r <= acc_r[AW-1] ^ dneg_r;
      dsh_r  <= AW'(mul_r) << MW;
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dsh_r;
      q_r   <= {q_r[MW-1:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  // Result value: quotient bit above 32 bits means overflow.
  always_comb begin
    if (tab_bad_r || degen) begin
      val = '0;
    end else if (qneg_r) begin
      val = (q_r[MW] || q_r[MW-1:0] > ntbi_pkg::VAL_MIN) ? ntbi_pkg::VAL_MIN
                                                           : VW'(0) - q_r[MW-1:0];
    end else begin
      val = (q_r[MW] || q_r[MW-1]) ? ntbi_pkg::VAL_MAX : q_r[MW-1:0];
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value       <= val;
      out_row_segment <= tab_bad_r ? '0 : seg_r[0];
      out_col_segment <= tab_bad_r ? '0 : seg_r[1];
      out_degenerate  <= tab_bad_r || degen;
    end
  end

endmodule

@@ design/nldm_table_bilinear_interpolator.sv @@
// Bilinear lookup over stored two-dimensional delay and slew tables, Q16.16.
// A write word (slew point, load point or grid value) gives no result.
// A query scans both axes in parallel one point per cycle, reads the
// segment end points and the four corner values, forms the four weighted
// terms on one shared 32x32 multiplier and divides one quotient bit per
// cycle. A chosen segment of zero width skips the multiply and divide, and
// a table number out of range goes straight to the result. The block works
// on one query at a time; a finished result waits in the output register
// while the next word is taken.
module nldm_table_bilinear_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [ntbi_pkg::TAB_W-1:0]        in_table_id,
  input  logic [ntbi_pkg::POS_W-1:0]        in_row_pos,
  input  logic [ntbi_pkg::POS_W-1:0]        in_col_pos,
  input  logic signed [ntbi_pkg::VAL_W-1:0] in_write_value,
  input  logic signed [ntbi_pkg::VAL_W-1:0] in_query_slew,
  input  logic signed [ntbi_pkg::VAL_W-1:0] in_query_load,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ntbi_pkg::VAL_W-1:0] out_value,
  output logic [ntbi_pkg::SEG_W-1:0]        out_row_segment,
  output logic [ntbi_pkg::SEG_W-1:0]        out_col_segment,
  output logic                              out_degenerate
);

  ntbi_pkg::dp_cmd_t  cmd;
  ntbi_pkg::dp_stat_t stat;

  // Sequencer.
  ntbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table storage and arithmetic.
  ntbi_dp u_dp (
    .clk             (clk),
    .in_func         (in_func),
    .in_table_id     (in_table_id),
    .in_row_pos      (in_row_pos),
    .in_col_pos      (in_col_pos),
    .in_write_value  (in_write_value),
    .in_query_slew   (in_query_slew),
    .in_query_load   (in_query_load),
    .cmd             (cmd),
    .stat            (stat),
    .out_value       (out_value),
    .out_row_segment (out_row_segment),
    .out_col_segment (out_col_segment),
    .out_degenerate  (out_degenerate)
  );

endmodule

@@ design/ntbi_checker.sv @@
`include "nldm_table_bilinear_interpolator_assert.svh"

module ntbi_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ntbi_pkg::VAL_W-1:0] out_value,
  input logic [ntbi_pkg::SEG_W-1:0]        out_row_segment,
  input logic [ntbi_pkg::SEG_W-1:0]        out_col_segment,
  input logic                              out_degenerate
);

  // A stalled result word stays offered.
  `NTBI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result word keeps its value.
  `NTBI_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_value) && $stable(out_degenerate), "result changed while stalled")

  // A zero-width segment always answers zero.
  `NTBI_ASSERT_NOW(a_degen_zero, out_valid && out_degenerate, out_value == '0, "degenerate result is not zero")

  // Reported segments lie inside the axes.
  `NTBI_ASSERT_NOW(a_seg_range, out_valid, out_row_segment <= ntbi_pkg::SEG_W'(ntbi_pkg::TABLE_DIM - 2) && out_col_segment <= ntbi_pkg::SEG_W'(ntbi_pkg::TABLE_DIM - 2), "segment out of range")

endmodule

bind nldm_table_bilinear_interpolator ntbi_checker u_ntbi_checker (.*);

@@ dv/nldm_table_bilinear_interpolator_test.sv @@
module nldm_table_bilinear_interpolator_test;

  localparam int DIM        = ntbi_pkg::TABLE_DIM;
  localparam int NTAB       = ntbi_pkg::NUM_TABLES;
  localparam int WORD_COUNT = 1350;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 600;
  localparam int SETTLE     = 150;
  localparam int AX_SLEW    = 0;
  localparam int AX_LOAD    = 1;

  typedef struct {
    ntbi_pkg::func_t                func;
    logic [ntbi_pkg::TAB_W-1:0]     tab;
    logic [ntbi_pkg::POS_W-1:0]     rp;
    logic [ntbi_pkg::POS_W-1:0]     cp;
    logic [ntbi_pkg::VAL_W-1:0]     wv;
    logic [ntbi_pkg::VAL_W-1:0]     qs;
    logic [ntbi_pkg::VAL_W-1:0]     ql;
    bit                             drain;
  } word_t;

  typedef struct {
    logic [ntbi_pkg::VAL_W-1:0] value;
    logic [ntbi_pkg::SEG_W-1:0] row_seg;
    logic [ntbi_pkg::SEG_W-1:0] col_seg;
    logic                       degen;
  } lookup_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [1:0]                        in_func;
  logic [ntbi_pkg::TAB_W-1:0]        in_table_id;
  logic [ntbi_pkg::POS_W-1:0]        in_row_pos;
  logic [ntbi_pkg::POS_W-1:0]        in_col_pos;
  logic signed [ntbi_pkg::VAL_W-1:0] in_write_value;
  logic signed [ntbi_pkg::VAL_W-1:0] in_query_slew;
  logic signed [ntbi_pkg::VAL_W-1:0] in_query_load;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [ntbi_pkg::VAL_W-1:0] out_value;
  logic [ntbi_pkg::SEG_W-1:0]        out_row_segment;
  logic [ntbi_pkg::SEG_W-1:0]        out_col_segment;
  logic                              out_degenerate;

  nldm_table_bilinear_interpolator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_table_id     (in_table_id),
    .in_row_pos      (in_row_pos),
    .in_col_pos      (in_col_pos),
    .in_write_value  (in_write_value),
    .in_query_slew   (in_query_slew),
    .in_query_load   (in_query_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_row_segment (out_row_segment),
    .out_col_segment (out_col_segment),
    .out_degenerate  (out_degenerate)
  );

  // Words waiting to be driven and lookups waiting to come back.
  word_t   word_q[$];
  lookup_t lookup_q[$];
  int      n_err;
  int      n_acc;
  bit      in_fire;

  // Table contents as the predictor sees them, updated on each accepted word.
  logic [ntbi_pkg::VAL_W-1:0] p_slew [NTAB][DIM];
  logic [ntbi_pkg::VAL_W-1:0] p_load [NTAB][DIM];
  logic [ntbi_pkg::VAL_W-1:0] p_grid [NTAB][DIM][DIM];

  // Table contents as the stimulus generator sees them.
  logic [ntbi_pkg::VAL_W-1:0] g_slew [NTAB][DIM];
  logic [ntbi_pkg::VAL_W-1:0] g_load [NTAB][DIM];
  bit                         g_full [NTAB];

  // Clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint axis_pt(int sel, int tab, int i);
    logic signed [ntbi_pkg::VAL_W-1:0] v;
    v = (sel == AX_SLEW) ? p_slew[tab][i] : p_load[tab][i];
    return longint'(v);
  endfunction

  // First segment holding x; clamps to the end segments otherwise.
  function automatic int find_seg(int sel, int tab, longint x);
    for (int i = 0; i < DIM - 1; i++) begin
      if (x >= axis_pt(sel, tab, i) && x <= axis_pt(sel, tab, i + 1)) return i;
    end
    return (x < axis_pt(sel, tab, 0)) ? 0 : DIM - 2;
  endfunction

  function automatic logic signed [127:0] corner(longint v, longint a, longint b);
    logic signed [127:0] x, y, z;
    x = v;
    y = a;
    z = b;
    return x * y * z;
  endfunction

  // Bilinear interpolation over the chosen cell, truncated and saturated.
  function automatic lookup_t interpolate(int tab, longint ts, longint cl);
    lookup_t                           res;
    int                                r, c;
    longint                            t1, t2, c1, c2;
    logic signed [ntbi_pkg::VAL_W-1:0] v11, v12, v21, v22;
    logic signed [127:0]               num, den, quo;
    r = find_seg(AX_SLEW, tab, ts);
    c = find_seg(AX_LOAD, tab, cl);
    res.row_seg = r[ntbi_pkg::SEG_W-1:0];
    res.col_seg = c[ntbi_pkg::SEG_W-1:0];
    t1 = axis_pt(AX_SLEW, tab, r);
    t2 = axis_pt(AX_SLEW, tab, r + 1);
    c1 = axis_pt(AX_LOAD, tab, c);
    c2 = axis_pt(AX_LOAD, tab, c + 1);
    if (t1 == t2 || c1 == c2) begin
      res.value = '0;
      res.degen = 1'b1;
      return res;
    end
    v11 = p_grid[tab][r][c];
    v12 = p_grid[tab][r][c + 1];
    v21 = p_grid[tab][r + 1][c];
    v22 = p_grid[tab][r + 1][c + 1];
    num = corner(v11, c2 - cl, t2 - ts) + corner(v12, cl - c1, t2 - ts)
        + corner(v21, c2 - cl, ts - t1) + corner(v22, cl - c1, ts - t1);
    den = corner(1, c2 - c1, t2 - t1);
    quo = num / den;
    if (quo > 128'sh7FFF_FFFF) res.value = ntbi_pkg::VAL_MAX;
    else if (quo < -128'sh8000_0000) res.value = ntbi_pkg::VAL_MIN;
    else res.value = quo[ntbi_pkg::VAL_W-1:0];
    res.degen = 1'b0;
    return res;
  endfunction

  // Apply one accepted word to the predictor state.
  task automatic apply_word(word_t w);
    lookup_t res;
    case (w.func)
      ntbi_pkg::FUNC_SLEW: if (w.rp < DIM) p_slew[w.tab][w.rp] = w.wv;
      ntbi_pkg::FUNC_LOAD: if (w.cp < DIM) p_load[w.tab][w.cp] = w.wv;
      ntbi_pkg::FUNC_GRID: if (w.rp < DIM && w.cp < DIM) p_grid[w.tab][w.rp][w.cp] = w.wv;
      default: begin
        if (w.tab >= NTAB) begin
          res.value   = '0;
          res.row_seg = '0;
          res.col_seg = '0;
          res.degen   = 1'b1;
        end else begin
          res = interpolate(w.tab, longint'($signed(w.qs)), longint'($signed(w.ql)));
        end
        lookup_q = {lookup_q, res};
      end
    endcase
  endtask

  // Stimulus helpers.
  task automatic add_word(ntbi_pkg::func_t f, int tab, int rp, int cp,
                          logic [ntbi_pkg::VAL_W-1:0] wv,
                          logic [ntbi_pkg::VAL_W-1:0] qs,
                          logic [ntbi_pkg::VAL_W-1:0] ql, bit drain);
    word_t w;
    w.func  = f;
    w.tab   = tab[ntbi_pkg::TAB_W-1:0];
    w.rp    = rp[ntbi_pkg::POS_W-1:0];
    w.cp    = cp[ntbi_pkg::POS_W-1:0];
    w.wv    = wv;
    w.qs    = qs;
    w.ql    = ql;
    w.drain = drain;
    word_q = {word_q, w};
    if (f == ntbi_pkg::FUNC_SLEW && rp < DIM) g_slew[tab][rp] = wv;
    if (f == ntbi_pkg::FUNC_LOAD && cp < DIM) g_load[tab][cp] = wv;
  endtask

  function automatic logic [ntbi_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return ntbi_pkg::VAL_MAX;
      1: return ntbi_pkg::VAL_MIN;
      2: return $urandom;
      default: return $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
  endfunction

  // Axis shapes: ascending, ascending with a repeated point, arbitrary,
  // and spread across the whole signed range.
  task automatic fill_table(int tab, int shape);
    longint pts[DIM];
    int     dup;
    pts[0] = longint'($urandom_range(0, 4000)) * 4096 - 8192000;
    for (int i = 1; i < DIM; i++) pts[i] = pts[i - 1] + $urandom_range(1, 1 << 18);
    dup = $urandom_range(1, DIM - 1);
    for (int i = 0; i < DIM; i++) begin
      case (shape)
        1: if (i == dup) pts[i] = pts[i - 1];
        2: pts[i] = longint'($signed($urandom));
        3: pts[i] = (i == DIM - 1) ? 64'sd2147483647 : -64'sd2147483648 + i * 64'sd715827882;
        default: ;
      endcase
      add_word(ntbi_pkg::FUNC_SLEW, tab, i, $urandom_range(0, 7),
               pts[i][ntbi_pkg::VAL_W-1:0], $urandom, $urandom, 0);
    end
    for (int i = 0; i < DIM; i++) begin
      add_word(ntbi_pkg::FUNC_LOAD, tab, $urandom_range(0, 7), i,
               pts[DIM - 1 - i][ntbi_pkg::VAL_W-1:0] ^ ((shape == 2) ? $urandom : 0),
               $urandom, $urandom, 0);
    end
    // Load axis ascending for the regular shapes.
    if (shape != 2) begin
      for (int i = 0; i < DIM; i++) begin
        add_word(ntbi_pkg::FUNC_LOAD, tab, 0, i,
                 pts[i][ntbi_pkg::VAL_W-1:0] + ((shape == 3) ? 0 : i), 0, 0, 0);
      end
    end
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        add_word(ntbi_pkg::FUNC_GRID, tab, r, c,
                 (shape == 3) ? (((r + c) % 2) ? ntbi_pkg::VAL_MAX : ntbi_pkg::VAL_MIN)
                              : rand_value(), $urandom, $urandom, 0);
      end
    end
    g_full[tab] = 1;
  endtask

  function automatic logic [ntbi_pkg::VAL_W-1:0] pick_coord(int tab, int sel);
    int     i;
    longint lo, hi, v;
    i  = $urandom_range(0, DIM - 2);
    lo = longint'($signed((sel == AX_SLEW) ? g_slew[tab][i] : g_load[tab][i]));
    hi = longint'($signed((sel == AX_SLEW) ? g_slew[tab][i + 1] : g_load[tab][i + 1]));
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? ntbi_pkg::VAL_MAX : ntbi_pkg::VAL_MIN;
      2: return lo[ntbi_pkg::VAL_W-1:0];
      7: v = lo + $urandom_range(0, 1 << 21) - (1 << 20);
      default: v = lo + longint'($urandom_range(0, 1000)) * (hi - lo) / 1000;
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[ntbi_pkg::VAL_W-1:0];
  endfunction

  task automatic add_query(int tab);
    add_word(ntbi_pkg::FUNC_QUERY, tab, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
             pick_coord(tab, AX_SLEW), pick_coord(tab, AX_LOAD), 0);
  endtask

  // Driver: bursts of words with random gaps, changing at the falling edge.
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() == 0 || (word_q[0].drain && lookup_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_func        <= word_q[0].func;
        in_table_id    <= word_q[0].tab;
        in_row_pos     <= word_q[0].rp;
        in_col_pos     <= word_q[0].cp;
        in_write_value <= word_q[0].wv;
        in_query_slew  <= word_q[0].qs;
        in_query_load  <= word_q[0].ql;
        in_valid       <= 1'b1;
        void'(word_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern cycling through four settings, plus one long hold-off.
  int rx_cyc;
  int hold_left;
  bit hold_done;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_cyc <= rx_cyc + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && n_acc >= 400) begin
        hold_done <= 1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cyc / 64) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Monitor, predictor update and watchdog at the rising edge.
  int idle_cyc;

  always @(posedge clk) begin
    if (rst_n) begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          $error("result word with no lookup pending: value %h", out_value);
          n_err++;
        end else begin
          if (out_value !== lookup_q[0].value) begin
            $error("value: expected %h, got %h", lookup_q[0].value, out_value);
            n_err++;
          end
          if (out_row_segment !== lookup_q[0].row_seg) begin
            $error("row_segment: expected %0d, got %0d", lookup_q[0].row_seg, out_row_segment);
            n_err++;
          end
          if (out_col_segment !== lookup_q[0].col_seg) begin
            $error("col_segment: expected %0d, got %0d", lookup_q[0].col_seg, out_col_segment);
            n_err++;
          end
          if (out_degenerate !== lookup_q[0].degen) begin
            $error("degenerate: expected %0d, got %0d", lookup_q[0].degen, out_degenerate);
            n_err++;
          end
          void'(lookup_q.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        word_t w;
        w.func = ntbi_pkg::func_t'(in_func);
        w.tab  = in_table_id;
        w.rp   = in_row_pos;
        w.cp   = in_col_pos;
        w.wv   = in_write_value;
        w.qs   = in_query_slew;
        w.ql   = in_query_load;
        apply_word(w);
        n_acc++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int tab;
    bit drain_set;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    in_func        = '0;
    in_table_id    = '0;
    in_row_pos     = '0;
    in_col_pos     = '0;
    in_write_value = '0;
    in_query_slew  = '0;
    in_query_load  = '0;
    in_fire        = 0;
    n_err          = 0;
    n_acc          = 0;
    idle_cyc       = 0;
    burst_left     = 0;
    gap_left       = 0;
    rx_cyc         = 0;
    hold_left      = 0;
    hold_done      = 0;
    drain_set      = 0;
    for (int i = 0; i < NTAB; i++) g_full[i] = 0;

    // Tables of each axis shape.
    fill_table(0, 0);
    fill_table(1, 1);
    fill_table(2, 2);
    fill_table(31, 3);

    // Directed lookups: inside, below, above, on points, range extremes,
    // repeated axis point, unordered axis, and ignored out-of-range writes.
    add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, g_slew[0][2] + 5, g_load[0][3] + 7, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 0, 7, 7, '1, g_slew[0][0] - 100, g_load[0][0] - 100, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, g_slew[0][DIM - 1] + 100,
             g_load[0][DIM - 1] + 9, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, g_slew[0][DIM - 1], g_load[0][0], 0);
    add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, ntbi_pkg::VAL_MIN, ntbi_pkg::VAL_MAX, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, ntbi_pkg::VAL_MAX, ntbi_pkg::VAL_MIN, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 1, 0, 0, 0, g_slew[1][3], g_load[1][3], 0);
    add_word(ntbi_pkg::FUNC_QUERY, 2, 0, 0, 0, $urandom, $urandom, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 31, 0, 0, 0, ntbi_pkg::VAL_MAX, ntbi_pkg::VAL_MIN, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 31, 0, 0, 0, ntbi_pkg::VAL_MIN, 0, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 31, 0, 0, 0, 32'h0001_0000, ntbi_pkg::VAL_MAX, 0);
    add_word(ntbi_pkg::FUNC_SLEW, 0, 7, 3, ntbi_pkg::VAL_MAX, 0, 0, 0);
    add_word(ntbi_pkg::FUNC_LOAD, 0, 3, 7, ntbi_pkg::VAL_MIN, 0, 0, 0);
    add_word(ntbi_pkg::FUNC_GRID, 0, 7, 2, ntbi_pkg::VAL_MAX, 0, 0, 0);
    add_word(ntbi_pkg::FUNC_GRID, 0, 2, 7, ntbi_pkg::VAL_MIN, 0, 0, 0);
    add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, g_slew[0][1] + 3, g_load[0][5] - 3, 0);

    // Random part: mostly lookups on full tables, with refills and writes.
    while (word_q.size() < WORD_COUNT) begin
      if (!drain_set && word_q.size() > WORD_COUNT / 2) begin
        drain_set = 1;
        add_word(ntbi_pkg::FUNC_QUERY, 0, 0, 0, 0, $urandom, $urandom, 1);
      end
      case ($urandom_range(0, 19))
        0: fill_table($urandom_range(0, NTAB - 1), $urandom_range(0, 3));
        1, 2, 3, 4: add_word(ntbi_pkg::func_t'($urandom_range(0, 2)),
                             $urandom_range(0, NTAB - 1),
                             $urandom_range(0, 7), $urandom_range(0, 7), rand_value(),
                             $urandom, $urandom, 0);
        default: begin
          do tab = $urandom_range(0, NTAB - 1); while (!g_full[tab]);
          add_query(tab);
        end
      endcase
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_valid) @(posedge clk);
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
